// ----- rtl/draw_list_sorter_top_assert.svh -----
// Assertion macros for the draw list sorter top level.
`ifndef DRAW_LIST_SORTER_TOP_ASSERT_SVH
`define DRAW_LIST_SORTER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define DLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dls_pkg.sv -----
// Shared types, constants and compare function of the draw list sorter.
package dls_pkg;

  localparam int DLS_MAX_RECORDS = 64;
  localparam int KEY_W  = 64;
  localparam int ID_W   = 32;
  localparam int SURF_W = 32;
  localparam int SLOT_W = 32;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   id;
    logic [SURF_W-1:0] surf;
    logic [SLOT_W-1:0] slot;
  } rec_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic set_ovf;
    logic clr_ovf;
  } dls_cmd_t;

  typedef struct packed {
    logic full;
    logic one;
    logic empty;
  } dls_sts_t;

  // True when x orders strictly before y: key, then id, then surface.
  function automatic logic rec_before(rec_t x, rec_t y);
    logic res;
    if (x.key != y.key) begin
      res = (x.key < y.key);
    end else if (x.id != y.id) begin
      res = (x.id < y.id);
    end else begin
      res = (x.surf < y.surf);
    end
    return res;
  endfunction

endpackage

// ----- rtl/dls_in_if.sv -----
// Input channel interface carrying one draw record per transfer.
interface dls_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sort_key;
  logic [31:0] draw_uid;
  logic [31:0] surface;
  logic [31:0] inst_ref;
  logic        last_item;

  modport source (output valid, output sort_key, output draw_uid, output surface,
                  output inst_ref, output last_item, input ready);
  modport sink   (input valid, input sort_key, input draw_uid, input surface,
                  input inst_ref, input last_item, output ready);
endinterface

// ----- rtl/dls_out_if.sv -----
// Result channel interface carrying one sorted draw record per transfer.
interface dls_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_key;
  logic [31:0] out_draw_uid;
  logic [31:0] out_surface;
  logic [31:0] out_inst_ref;
  logic        out_last;
  logic        dropped;

  modport source (output valid, output out_key, output out_draw_uid, output out_surface,
                  output out_inst_ref, output out_last, output dropped, input ready);
  modport sink   (input valid, input out_key, input out_draw_uid, input out_surface,
                  input out_inst_ref, input out_last, input dropped, output ready);
endinterface

// ----- rtl/dls_ctrl.sv -----
// Controller state machine: load phase and drain phase of a batch.
module dls_ctrl
  import dls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  dls_sts_t sts,
  output dls_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_ready && sts.one) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_LOAD: begin
        in_ready    = 1'b1;
        // Drop the record once the cell row is full
        cmd.insert  = in_valid && !sts.full;
        cmd.set_ovf = in_valid && sts.full;
      end
      ST_DRAIN: begin
        out_valid   = 1'b1;
        cmd.pop     = out_ready;
        cmd.clr_ovf = out_ready && sts.one;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/dls_datapath.sv -----
// Datapath: sorted row of record cells with broadcast insert and shift-out drain.
module dls_datapath
  import dls_pkg::*;
#(
  parameter int MAX_RECORDS = DLS_MAX_RECORDS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dls_cmd_t cmd,
  input  rec_t     new_rec,
  output rec_t     head_rec,
  output logic     ovf,
  output dls_sts_t sts
);

  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic [MAX_RECORDS-1:0] goes_before;
  rec_t             cells_r   [MAX_RECORDS];
  rec_t             cells_nxt [MAX_RECORDS];

  // Each cell compares the incoming record with its own content; empty cells
  // count as later than anything.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    assign goes_before[i] = (CW'(i) >= count_r) || rec_before(new_rec, cells_r[i]);

    if (i == 0) begin : g_first
      always_comb begin
        cells_nxt[i] = cells_r[i];
        if (cmd.insert && goes_before[i]) begin
          cells_nxt[i] = new_rec;
        end else if (cmd.pop) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
    end else if (i == MAX_RECORDS - 1) begin : g_final
      always_comb begin
        cells_nxt[i] = cells_r[i];
        if (cmd.insert && goes_before[i]) begin
          cells_nxt[i] = goes_before[i-1] ? cells_r[i-1] : new_rec;
        end
      end
    end else begin : g_mid
      always_comb begin
        cells_nxt[i] = cells_r[i];
        if (cmd.insert && goes_before[i]) begin
          // Shift right behind the insertion point
          cells_nxt[i] = goes_before[i-1] ? cells_r[i-1] : new_rec;
        end else if (cmd.pop) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
    end

    always_ff @(posedge clk) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
    ovf_nxt = ovf_r;
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end else if (cmd.clr_ovf) begin
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign head_rec  = cells_r[0];
  assign ovf       = ovf_r;
  assign sts.full  = (count_r == CW'(MAX_RECORDS));
  assign sts.one   = (count_r == CW'(1));
  assign sts.empty = (count_r == '0);

endmodule

// ----- rtl/draw_list_sorter_top.sv -----
// Top level of the draw list sorter: controller, datapath and channel wiring.
//
//   channel   direction  payload                                    handshake
//   in_rec    sink       sort_key, draw_uid, surface, slot, last     valid/ready
//   out_rec   source     key, draw_uid, surface, slot, last, drop    valid/ready
//
// Load: one record per cycle, inserted in order into a row of MAX_RECORDS cells.
// Drain: one record per cycle while out_rec.ready is high, from the head cell, shifting the row down.
// in_rec.ready is low while a batch drains; out_rec stalls simply hold the head.
// Synchronous active-low reset empties the row; no clearing pass is needed.
module draw_list_sorter_top
  import dls_pkg::*;
#(
  parameter int MAX_RECORDS = DLS_MAX_RECORDS
) (
  input  logic      clk,
  input  logic      rst_n,
  dls_in_if.sink    in_rec,
  dls_out_if.source out_rec
);

  `include "draw_list_sorter_top_assert.svh"

  dls_cmd_t cmd;
  dls_sts_t sts;
  rec_t     new_rec;
  rec_t     head_rec;
  logic     ovf;

  assign new_rec.key  = in_rec.sort_key;
  assign new_rec.id   = in_rec.draw_uid;
  assign new_rec.surf = in_rec.surface;
  assign new_rec.slot = in_rec.inst_ref;

  dls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_rec.valid),
    .in_last   (in_rec.last_item),
    .in_ready  (in_rec.ready),
    .out_ready (out_rec.ready),
    .out_valid (out_rec.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  dls_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .new_rec  (new_rec),
    .head_rec (head_rec),
    .ovf      (ovf),
    .sts      (sts)
  );

  assign out_rec.out_key      = head_rec.key;
  assign out_rec.out_draw_uid = head_rec.id;
  assign out_rec.out_surface  = head_rec.surf;
  assign out_rec.out_inst_ref = head_rec.slot;
  assign out_rec.out_last     = sts.one;
  assign out_rec.dropped      = sts.one && ovf;

  `DLS_ASSERT_IMP(a_no_overlap, in_rec.ready, !out_rec.valid, "load and drain overlap")
  `DLS_ASSERT_IMP(a_valid_nonempty, out_rec.valid, !sts.empty, "drain from empty row")
  `DLS_ASSERT_IMP(a_drop_on_last, out_rec.valid && out_rec.dropped, out_rec.out_last,
                  "drop flag off the final record")
  `DLS_ASSERT_NXT(a_batch_done, out_rec.valid && out_rec.ready && out_rec.out_last,
                  sts.empty && in_rec.ready && !ovf, "row not empty after batch")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the draw list sorter: directed, capacity and random batches.
`timescale 1ns / 100ps

module testbench;
  import dls_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 2 * DLS_MAX_RECORDS + 20;

  typedef struct {
    rec_t r;
    bit   fin;
    bit   drop;
  } sorted_draw_t;

  logic clk;
  logic rst_n;

  dls_in_if  in_ch ();
  dls_out_if out_ch ();

  draw_list_sorter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rec (in_ch),
    .out_rec(out_ch)
  );

  rec_t         staged_draws[$];
  bit           staged_overflow;
  sorted_draw_t pending_draws[$];
  int           error_count;
  int           quiet_cycles;
  int           out_hold_left;
  bit           idle_in;
  bit           idle_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Strict ascending order over key, then {draw uid, surface}.
  function automatic bit ranks_ahead(rec_t a, rec_t b);
    return (a.key < b.key) || (a.key == b.key && {a.id, a.surf} < {b.id, b.surf});
  endfunction

  function automatic rec_t draw(logic [63:0] k, logic [31:0] i, logic [31:0] s,
                                logic [31:0] sl);
    rec_t r;
    r = '{key: k, id: i, surf: s, slot: sl};
    return r;
  endfunction

  // Small pools near zero and the top make ties on id and surface common.
  function automatic logic [31:0] pick_word32();
    logic [31:0] w;
    case ($urandom_range(2))
      0: w = $urandom;
      1: w = 32'($urandom_range(2));
      default: w = 32'hFFFF_FFFF - 32'($urandom_range(1));
    endcase
    return w;
  endfunction

  function automatic rec_t random_draw();
    rec_t r;
    case ($urandom_range(3))
      0: r.key = {$urandom, $urandom};
      1: r.key = 64'($urandom_range(3));
      2: r.key = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(2));
      default: r.key = {1'b1, 63'($urandom_range(2))};
    endcase
    r.id   = pick_word32();
    r.surf = pick_word32();
    r.slot = $urandom;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_draw(rec_t r, bit last);
    if (idle_in && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sort_key  <= r.key;
    in_ch.draw_uid  <= r.id;
    in_ch.surface   <= r.surf;
    in_ch.inst_ref  <= r.slot;
    in_ch.last_item <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_draws.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_cases();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    // single-record batches at both extremes
    send_draw(draw('1, '1, '1, '1), 1'b1);
    send_draw(draw('0, '0, '0, '0), 1'b1);
    // full tie keeps arrival order; surface and id break key ties
    send_draw(draw(64'd5, 32'd7, 32'd3, 32'd1), 1'b0);
    send_draw(draw(64'd5, 32'd7, 32'd3, 32'd2), 1'b0);
    send_draw(draw(64'd5, 32'd7, 32'd2, 32'd3), 1'b0);
    send_draw(draw(64'd5, 32'd6, 32'd9, 32'd4), 1'b0);
    send_draw(draw(64'h8000_0000_0000_0000, '0, '0, 32'd5), 1'b0);
    send_draw(draw(64'h7FFF_FFFF_FFFF_FFFF, '1, '1, 32'd6), 1'b0);
    send_draw(draw('0, '1, '1, '0), 1'b0);
    send_draw(draw('1, '0, '0, '1), 1'b1);
    // top bits of id and surface must compare unsigned
    send_draw(draw(64'd9, 32'h8000_0000, 32'd0, 32'hA5A5_A5A5), 1'b0);
    send_draw(draw(64'd9, 32'h7FFF_FFFF, 32'd0, 32'h5A5A_5A5A), 1'b0);
    send_draw(draw(64'd8, 32'd1, 32'h8000_0000, 32'hFFFF_0000), 1'b0);
    send_draw(draw(64'd8, 32'd1, 32'h7FFF_FFFF, 32'h0000_FFFF), 1'b0);
    send_draw(draw(64'd3, 32'd0, 32'd0, 32'h1234_5678), 1'b1);
    wait_drained();
  endtask

  task automatic test_capacity();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    // exactly full: no drop
    for (int i = 0; i < DLS_MAX_RECORDS; i++) begin
      send_draw(random_draw(), i == DLS_MAX_RECORDS - 1);
    end
    // one past full: the last item itself is discarded and the drop flagged
    for (int i = 0; i <= DLS_MAX_RECORDS; i++) begin
      send_draw(random_draw(), i == DLS_MAX_RECORDS);
    end
    wait_drained();
  endtask

  task automatic test_random_batches(int item_goal, bit with_idle);
    int sent;
    int batch_len;
    idle_in  = with_idle;
    idle_out = with_idle;
    sent = 0;
    while (sent < item_goal) begin
      batch_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < batch_len; i++) begin
        send_draw(random_draw(), i == batch_len - 1);
      end
      sent += batch_len;
    end
    wait_drained();
  endtask

  // Result side back-pressure: random stall runs, only while idle_out is set.
  always @(negedge clk) begin
    if (out_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      out_hold_left--;
    end else if (idle_out && $urandom_range(99) < 6) begin
      out_ch.ready <= 1'b0;
      out_hold_left = $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Track the batch on each input transfer; on the last item queue the sorted run.
  always @(posedge clk) begin : predict_sorted
    rec_t         cur;
    sorted_draw_t d;
    int           j;
    if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      cur = draw(in_ch.sort_key, in_ch.draw_uid, in_ch.surface, in_ch.inst_ref);
      if (staged_draws.size() < DLS_MAX_RECORDS) begin
        j = staged_draws.size();
        staged_draws.push_back(cur);
        // shift only past strictly larger records, so ties stay in arrival order
        while (j > 0 && ranks_ahead(cur, staged_draws[j-1])) begin
          staged_draws[j] = staged_draws[j-1];
          j--;
        end
        staged_draws[j] = cur;
      end else begin
        staged_overflow = 1'b1;
      end
      if (in_ch.last_item) begin
        foreach (staged_draws[k]) begin
          d.r    = staged_draws[k];
          d.fin  = (k == staged_draws.size() - 1);
          d.drop = d.fin && staged_overflow;
          pending_draws.push_back(d);
        end
        staged_draws.delete();
        staged_overflow = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    sorted_draw_t exp_d;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected result key=%h id=%h", out_ch.out_key,
                                  out_ch.out_draw_uid));
      end else begin
        exp_d = pending_draws.pop_front();
        if (out_ch.out_key !== exp_d.r.key)
          report_mismatch($sformatf("out_key %h, expected %h", out_ch.out_key, exp_d.r.key));
        if (out_ch.out_draw_uid !== exp_d.r.id)
          report_mismatch($sformatf("out_draw_uid %h, expected %h", out_ch.out_draw_uid,
                                    exp_d.r.id));
        if (out_ch.out_surface !== exp_d.r.surf)
          report_mismatch($sformatf("out_surface %h, expected %h", out_ch.out_surface,
                                    exp_d.r.surf));
        if (out_ch.out_inst_ref !== exp_d.r.slot)
          report_mismatch($sformatf("out_inst_ref %h, expected %h",
                                    out_ch.out_inst_ref, exp_d.r.slot));
        if (out_ch.out_last !== exp_d.fin)
          report_mismatch($sformatf("out_last %b, expected %b", out_ch.out_last, exp_d.fin));
        if (out_ch.dropped !== exp_d.drop)
          report_mismatch($sformatf("dropped %b, expected %b", out_ch.dropped, exp_d.drop));
      end
    end
  end

  // End the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("draw_list_sorter_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    error_count     = 0;
    quiet_cycles    = 0;
    out_hold_left   = 0;
    idle_in         = 1'b0;
    idle_out        = 1'b0;
    staged_overflow = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sort_key  <= '0;
    in_ch.draw_uid  <= '0;
    in_ch.surface   <= '0;
    in_ch.inst_ref  <= '0;
    in_ch.last_item <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_capacity();
    test_random_batches(110, 1'b0);
    test_random_batches(120, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("draw_list_sorter_top regression: pass");
    end else begin
      $display("draw_list_sorter_top regression: fail");
    end
    $finish;
  end

endmodule
